// ===== sv/esc_pkg.sv =====
// ----------------------------------------------------------------------------
// esc_pkg: shared types, constants and character classes
// Sizes, stack entry layout, bracket status codes and the character
// predicates used by the expression syntax checker.
// ----------------------------------------------------------------------------
package esc_pkg;

	localparam int STACK_DEPTH   = 32;
	localparam int POSITION_BITS = 12;
	localparam int CHAR_W        = 8;
	localparam int STATUS_W      = 3;
	localparam int CNT_W         = $clog2(STACK_DEPTH + 1);
	localparam int IDX_W         = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int IN_DATA_W     = ((CHAR_W + 7) / 8) * 8;
	localparam int OUT_FIELDS_W  = 2 * POSITION_BITS + 2 * CHAR_W + 1;
	localparam int OUT_DATA_W    = ((OUT_FIELDS_W + 7) / 8) * 8;

	localparam logic [CHAR_W-1:0] PRINT_LO  = 8'd32;
	localparam logic [CHAR_W-1:0] PRINT_HI  = 8'd126;
	localparam logic [CHAR_W-1:0] CH_DQUOTE = 8'h22;
	localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;
	localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
	localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;

	typedef logic [CHAR_W-1:0] char_t;
	typedef logic [POSITION_BITS-1:0] pos_t;

	typedef enum logic [1:0] {
		KIND_PAREN  = 2'd0,
		KIND_SQUARE = 2'd1,
		KIND_CURLY  = 2'd2
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		BS_NONE       = 3'd0,
		BS_UNEXPECTED = 3'd1,
		BS_MISMATCH   = 3'd2,
		BS_UNCLOSED   = 3'd3,
		BS_TOO_DEEP   = 3'd4
	} bracket_status_t;

	typedef struct packed {
		kind_t kind;
		pos_t  pos;
	} stack_entry_t;

	typedef struct packed {
		logic         push;
		logic         pop;
		logic         clear;
		stack_entry_t entry;
	} stack_cmd_t;

	function automatic logic is_op(input char_t c);
		return c == "+" || c == "-" || c == "*" || c == "/" || c == "^" ||
			c == "%" || c == "<" || c == ">" || c == "=" || c == "!" ||
			c == "&" || c == "|";
	endfunction

	function automatic logic pair_allowed(input char_t a, input char_t b);
		logic ok;
		ok = 1'b0;
		if (b == "=" && (a == "=" || a == "!" || a == "<" || a == ">"))
			ok = 1'b1;
		if ((a == "&" && b == "&") || (a == "|" && b == "|"))
			ok = 1'b1;
		if ((a == "+" || a == "-") && (b == "+" || b == "-"))
			ok = 1'b1;
		return ok;
	endfunction

	function automatic logic is_opener(input char_t c);
		return c == "(" || c == "[" || c == "{";
	endfunction

	function automatic logic is_closer(input char_t c);
		return c == ")" || c == "]" || c == "}";
	endfunction

	function automatic kind_t kind_of(input char_t c);
		kind_t k;
		if (c == "[" || c == "]")
			k = KIND_SQUARE;
		else if (c == "{" || c == "}")
			k = KIND_CURLY;
		else
			k = KIND_PAREN;
		return k;
	endfunction

	function automatic char_t opener_char(input kind_t k);
		char_t c;
		case (k)
			KIND_SQUARE: c = "[";
			KIND_CURLY:  c = "{";
			default:     c = "(";
		endcase
		return c;
	endfunction

	function automatic char_t closer_char(input kind_t k);
		char_t c;
		case (k)
			KIND_SQUARE: c = "]";
			KIND_CURLY:  c = "}";
			default:     c = ")";
		endcase
		return c;
	endfunction

	function automatic logic is_bad_char(input char_t c);
		return c != " " && c != CH_TAB && c != CH_LF && c != CH_CR &&
			(c < PRINT_LO || c > PRINT_HI);
	endfunction

endpackage

// ===== sv/expression_syntax_checker.sv =====
// ----------------------------------------------------------------------------
// expression_syntax_checker: streaming expression syntax checker
// One character per request in, one fault record per character out. Tracks
// string literals, operator pairs, stray characters and bracket nesting.
//
//   channel | dir | handshake        | payload
//   s_*     | in  | s_tvalid/tready  | tdata: char_code; tlast: final_char
//   m_*     | out | m_tvalid/tready  | tdata: fault record; tlast: end_marker
//
// The result passes the input register, then the result register; one character
// per cycle sustained while the output does not stall. The rate is set by the single
// bracket-stack access per character (top and below registers, one array slot).
// Reset clears control state and the stack count; stack contents are unset.
// A stalled output holds one result and one character in the input stage.
// ----------------------------------------------------------------------------
module expression_syntax_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [esc_pkg::IN_DATA_W-1:0]     s_tdata,  // char_code
	input  logic                              s_tlast,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// char_position, leading_operator, operator_pair_warning, bad_char_warning,
	// bracket_status, bracket_code, bracket_position, open_string_at_end,
	// trailing_operator, incomplete_ending, zero fill
	output logic [esc_pkg::OUT_DATA_W-1:0]    m_tdata,
	output logic                              m_tlast
);

	localparam int PB = esc_pkg::POSITION_BITS;

	// input stage
	logic                  valid_s1;
	esc_pkg::char_t        char_s1;
	logic                  last_s1;

	// result stage
	logic                                 valid_s2;
	logic [esc_pkg::OUT_DATA_W-1:0]       data_s2;
	logic                                 last_s2;

	// per-expression state
	logic                  in_string_q;
	logic                  escape_q;
	logic                  failed_q;
	esc_pkg::char_t        prior_char_q;
	logic                  prior_outside_q;
	esc_pkg::pos_t         position_q;

	logic                        adv;
	esc_pkg::stack_cmd_t         cmd;
	logic [esc_pkg::CNT_W-1:0]   stk_count;
	esc_pkg::stack_entry_t       stk_top;
	esc_pkg::stack_entry_t       stk_below;

	logic                        nxt_in_string;
	logic                        nxt_escape;
	logic                        nxt_failed;
	logic                        outside;
	logic                        push;
	logic                        pop;
	logic                        fin_open;
	esc_pkg::stack_entry_t       new_entry;
	esc_pkg::stack_entry_t       fin_top;
	logic                        lead;
	logic                        pairw;
	logic                        badc;
	esc_pkg::bracket_status_t    status;
	esc_pkg::char_t              bcode;
	esc_pkg::pos_t               bpos;
	logic                        openstr;
	logic                        trail;
	logic                        incomplete;
	logic [esc_pkg::OUT_DATA_W-1:0] res_data;

	assign adv      = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv;
	assign m_tvalid = valid_s2;
	assign m_tdata  = data_s2;
	assign m_tlast  = last_s2;

	always_comb begin
		nxt_in_string = in_string_q;
		nxt_escape    = escape_q;
		nxt_failed    = failed_q;
		outside       = 1'b0;
		push          = 1'b0;
		pop           = 1'b0;
		status        = esc_pkg::BS_NONE;
		bcode         = '0;
		bpos          = '0;
		openstr       = 1'b0;
		trail         = 1'b0;
		incomplete    = 1'b0;
		new_entry.kind = esc_pkg::kind_of(char_s1);
		new_entry.pos  = position_q;

		lead = position_q == '0 && (char_s1 == "*" || char_s1 == "/" ||
			char_s1 == "^" || char_s1 == "%");
		pairw = position_q != '0 && prior_outside_q && esc_pkg::is_op(prior_char_q) &&
			esc_pkg::is_op(char_s1) && !esc_pkg::pair_allowed(prior_char_q, char_s1);

		if (in_string_q) begin
			if (escape_q)
				nxt_escape = 1'b0;
			else if (char_s1 == esc_pkg::CH_BSLASH)
				nxt_escape = 1'b1;
			else if (char_s1 == esc_pkg::CH_DQUOTE)
				nxt_in_string = 1'b0;
		end else if (char_s1 == esc_pkg::CH_DQUOTE) begin
			nxt_in_string = 1'b1;
		end else begin
			outside = 1'b1;
		end

		badc = outside && esc_pkg::is_bad_char(char_s1);

		if (outside && !failed_q) begin
			if (esc_pkg::is_opener(char_s1)) begin
				if (stk_count == esc_pkg::CNT_W'(esc_pkg::STACK_DEPTH)) begin
					status     = esc_pkg::BS_TOO_DEEP;
					bcode      = char_s1;
					bpos       = position_q;
					nxt_failed = 1'b1;
				end else begin
					push = 1'b1;
				end
			end else if (esc_pkg::is_closer(char_s1)) begin
				if (stk_count == '0) begin
					status     = esc_pkg::BS_UNEXPECTED;
					bcode      = char_s1;
					bpos       = position_q;
					nxt_failed = 1'b1;
				end else if (stk_top.kind != esc_pkg::kind_of(char_s1)) begin
					status     = esc_pkg::BS_MISMATCH;
					bcode      = esc_pkg::closer_char(stk_top.kind);
					bpos       = position_q;
					nxt_failed = 1'b1;
				end else begin
					pop = 1'b1;
				end
			end
		end

		fin_open = push || (pop ? (stk_count > esc_pkg::CNT_W'(1)) : (stk_count != '0));
		fin_top  = push ? new_entry : (pop ? stk_below : stk_top);

		if (last_s1) begin
			if (!nxt_failed && fin_open) begin
				status = esc_pkg::BS_UNCLOSED;
				bcode  = esc_pkg::opener_char(fin_top.kind);
				bpos   = fin_top.pos;
			end
			openstr    = nxt_in_string;
			trail      = esc_pkg::is_op(char_s1);
			incomplete = esc_pkg::is_op(char_s1) || char_s1 == "," || char_s1 == ":";
		end

		res_data = '0;
		res_data[esc_pkg::OUT_FIELDS_W-1:0] = {incomplete, trail, openstr, bpos, bcode,
			status, badc, pairw, lead, position_q};

		cmd.push  = adv && push;
		cmd.pop   = adv && pop;
		cmd.clear = adv && last_s1;
		cmd.entry = new_entry;
	end

	esc_stack u_stack (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.count  (stk_count),
		.top    (stk_top),
		.below  (stk_below)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			char_s1 <= s_tdata[esc_pkg::CHAR_W-1:0];
			last_s1 <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			data_s2 <= res_data;
			last_s2 <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_string_q     <= 1'b0;
			escape_q        <= 1'b0;
			failed_q        <= 1'b0;
			prior_char_q    <= '0;
			prior_outside_q <= 1'b0;
			position_q      <= '0;
		end else if (adv) begin
			if (last_s1) begin
				in_string_q     <= 1'b0;
				escape_q        <= 1'b0;
				failed_q        <= 1'b0;
				prior_char_q    <= '0;
				prior_outside_q <= 1'b0;
				position_q      <= '0;
			end else begin
				in_string_q     <= nxt_in_string;
				escape_q        <= nxt_escape;
				failed_q        <= nxt_failed;
				prior_char_q    <= char_s1;
				prior_outside_q <= outside;
				if (position_q != {PB{1'b1}})
					position_q <= position_q + PB'(1);
			end
		end
	end

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> valid_s1 && valid_s2 && !m_tready)
		else $error("input stalled without a stalled result");

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stk_count <= esc_pkg::CNT_W'(esc_pkg::STACK_DEPTH))
		else $error("bracket stack count beyond depth");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		adv && last_s1 |=> position_q == '0 && stk_count == '0 && !failed_q && !in_string_q)
		else $error("state not cleared after final character");

	a_fault_latches: assert property (@(posedge clk) disable iff (!arst_n)
		adv && !last_s1 && status != esc_pkg::BS_NONE |=> failed_q)
		else $error("bracket fault did not stop bracket checking");

endmodule

// ===== sv/esc_stack.sv =====
// ----------------------------------------------------------------------------
// esc_stack: bounded bracket stack
// Top entry and the entry below it live in their own registers; deeper entries
// sit in an array that is written at one index and read at one index (two
// below the top) in the clocked block.
// ----------------------------------------------------------------------------
module esc_stack (
	input  logic                         clk,
	input  logic                         arst_n,
	input  esc_pkg::stack_cmd_t          cmd,
	output logic [esc_pkg::CNT_W-1:0]    count,
	output esc_pkg::stack_entry_t        top,
	output esc_pkg::stack_entry_t        below
);

	logic [esc_pkg::CNT_W-1:0] count_q;
	esc_pkg::stack_entry_t     top_q;
	esc_pkg::stack_entry_t     below_q;
	esc_pkg::stack_entry_t     body_q [esc_pkg::STACK_DEPTH];
	logic [esc_pkg::CNT_W-1:0] wr_full;
	logic [esc_pkg::CNT_W-1:0] rd_full;
	logic [esc_pkg::IDX_W-1:0] wr_idx;
	logic [esc_pkg::IDX_W-1:0] rd_idx;

	assign wr_full = count_q - esc_pkg::CNT_W'(1);
	assign rd_full = count_q - esc_pkg::CNT_W'(3);
	assign wr_idx  = wr_full[esc_pkg::IDX_W-1:0];
	assign rd_idx  = rd_full[esc_pkg::IDX_W-1:0];

	assign count = count_q;
	assign top   = top_q;
	assign below = below_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.clear) begin
			count_q <= '0;
		end else if (cmd.push) begin
			count_q <= count_q + esc_pkg::CNT_W'(1);
		end else if (cmd.pop) begin
			count_q <= count_q - esc_pkg::CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			top_q   <= cmd.entry;
			below_q <= top_q;
			if (count_q != '0)
				body_q[wr_idx] <= top_q;
		end else if (cmd.pop) begin
			top_q   <= below_q;
			below_q <= body_q[rd_idx];
		end
	end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: expression syntax checker testbench
// Streams expression characters into the checker with bursty input and a
// stalling output, predicts every fault record, and compares each result with
// the oldest pending expectation. Directed table first, then generated
// expressions (well formed, broken, deeply nested, noise).
// ----------------------------------------------------------------------------
module tb_top;

	localparam int RANDOM_ITEMS = 920;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int NO_KIND      = -1;
	localparam esc_pkg::pos_t POS_SAT = '1;

	typedef struct packed {
		logic                     endm;
		logic                     incomplete;
		logic                     trail;
		logic                     openstr;
		esc_pkg::pos_t            bpos;
		esc_pkg::char_t           code;
		esc_pkg::bracket_status_t status;
		logic                     badc;
		logic                     pairw;
		logic                     lead;
		esc_pkg::pos_t            position;
	} result_t;

	typedef struct packed {
		esc_pkg::char_t ch;
		logic           last;
		logic           typed;
		result_t        want;
	} row_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           s_tvalid = 1'b0;
	logic                           s_tready;
	logic [esc_pkg::IN_DATA_W-1:0]  s_tdata = '0;
	logic                           s_tlast = 1'b0;
	logic                           m_tvalid;
	logic                           m_tready = 1'b0;
	logic [esc_pkg::OUT_DATA_W-1:0] m_tdata;
	logic                           m_tlast;

	// checker state mirror
	logic           str_open;
	logic           esc_armed;
	esc_pkg::kind_t nest_kind [esc_pkg::STACK_DEPTH];
	esc_pkg::pos_t  nest_pos [esc_pkg::STACK_DEPTH];
	int             nest_depth;
	logic           nest_broken;
	esc_pkg::char_t prev_char;
	logic           prev_plain;
	esc_pkg::pos_t  char_pos;

	result_t        expected_faults[$];
	row_t           dir_rows[$];
	esc_pkg::char_t expr_text[$];
	int unsigned    fails = 0;
	int unsigned    cycles = 0;
	int             burst_left = 0;
	int             rx_left = 0;
	int             rx_mode = 0;
	int             rx_phase = 0;

	expression_syntax_checker u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	function automatic logic is_operator(input esc_pkg::char_t c);
		return c == "+" || c == "-" || c == "*" || c == "/" || c == "^" || c == "%" ||
			c == "<" || c == ">" || c == "=" || c == "!" || c == "&" || c == "|";
	endfunction

	function automatic logic pair_ok(input esc_pkg::char_t a, input esc_pkg::char_t b);
		return (b == "=" && (a == "=" || a == "!" || a == "<" || a == ">")) ||
			(a == "&" && b == "&") || (a == "|" && b == "|") ||
			((a == "+" || a == "-") && (b == "+" || b == "-"));
	endfunction

	function automatic int opener_kind(input esc_pkg::char_t c);
		case (c)
			"(":     return int'(esc_pkg::KIND_PAREN);
			"[":     return int'(esc_pkg::KIND_SQUARE);
			"{":     return int'(esc_pkg::KIND_CURLY);
			default: return NO_KIND;
		endcase
	endfunction

	function automatic int closer_kind(input esc_pkg::char_t c);
		case (c)
			")":     return int'(esc_pkg::KIND_PAREN);
			"]":     return int'(esc_pkg::KIND_SQUARE);
			"}":     return int'(esc_pkg::KIND_CURLY);
			default: return NO_KIND;
		endcase
	endfunction

	function automatic esc_pkg::char_t open_sym(input esc_pkg::kind_t k);
		case (k)
			esc_pkg::KIND_SQUARE: return "[";
			esc_pkg::KIND_CURLY:  return "{";
			default:              return "(";
		endcase
	endfunction

	function automatic esc_pkg::char_t close_sym(input esc_pkg::kind_t k);
		case (k)
			esc_pkg::KIND_SQUARE: return "]";
			esc_pkg::KIND_CURLY:  return "}";
			default:              return ")";
		endcase
	endfunction

	function automatic void add_char(input esc_pkg::char_t c);
		expr_text.insert(expr_text.size(), c);
	endfunction

	function automatic void clear_scan();
		str_open    = 1'b0;
		esc_armed   = 1'b0;
		nest_depth  = 0;
		nest_broken = 1'b0;
		prev_char   = '0;
		prev_plain  = 1'b0;
		char_pos    = '0;
	endfunction

	// fault record for one accepted character; advances the mirrored state
	function automatic result_t scan_char(input esc_pkg::char_t c, input logic last);
		result_t        r;
		logic           plain;
		int             ko;
		int             kc;
		esc_pkg::kind_t top;
		r = '0;
		r.status = esc_pkg::BS_NONE;
		plain = 1'b0;
		r.position = char_pos;
		r.endm = last;
		if (char_pos == 0 && (c == "*" || c == "/" || c == "^" || c == "%"))
			r.lead = 1'b1;
		if (char_pos != 0 && prev_plain && is_operator(prev_char) && is_operator(c) &&
			!pair_ok(prev_char, c))
			r.pairw = 1'b1;

		if (str_open) begin
			if (esc_armed)
				esc_armed = 1'b0;
			else if (c == esc_pkg::CH_BSLASH)
				esc_armed = 1'b1;
			else if (c == esc_pkg::CH_DQUOTE)
				str_open = 1'b0;
		end else if (c == esc_pkg::CH_DQUOTE) begin
			str_open = 1'b1;
		end else begin
			plain = 1'b1;
		end

		if (plain) begin
			ko = opener_kind(c);
			kc = closer_kind(c);
			if (c != " " && c != esc_pkg::CH_TAB && c != esc_pkg::CH_LF &&
				c != esc_pkg::CH_CR && (c < esc_pkg::PRINT_LO || c > esc_pkg::PRINT_HI))
				r.badc = 1'b1;
			if (!nest_broken && ko != NO_KIND) begin
				if (nest_depth >= esc_pkg::STACK_DEPTH) begin
					r.status = esc_pkg::BS_TOO_DEEP;
					r.code = c;
					r.bpos = char_pos;
					nest_broken = 1'b1;
				end else begin
					nest_kind[nest_depth] = esc_pkg::kind_t'(ko);
					nest_pos[nest_depth] = char_pos;
					nest_depth++;
				end
			end else if (!nest_broken && kc != NO_KIND) begin
				if (nest_depth == 0) begin
					r.status = esc_pkg::BS_UNEXPECTED;
					r.code = c;
					r.bpos = char_pos;
					nest_broken = 1'b1;
				end else begin
					top = nest_kind[nest_depth-1];
					if (top != esc_pkg::kind_t'(kc)) begin
						r.status = esc_pkg::BS_MISMATCH;
						r.code = close_sym(top);
						r.bpos = char_pos;
						nest_broken = 1'b1;
					end else begin
						nest_depth--;
					end
				end
			end
		end

		if (last) begin
			if (!nest_broken && nest_depth > 0) begin
				r.status = esc_pkg::BS_UNCLOSED;
				r.code = open_sym(nest_kind[nest_depth-1]);
				r.bpos = nest_pos[nest_depth-1];
			end
			r.openstr = str_open;
			r.trail = is_operator(c);
			r.incomplete = is_operator(c) || c == "," || c == ":";
			clear_scan();
		end else begin
			prev_char = c;
			prev_plain = plain;
			if (char_pos != POS_SAT)
				char_pos++;
		end
		return r;
	endfunction

	function automatic result_t unpack_result(input logic [esc_pkg::OUT_DATA_W-1:0] d,
		input logic l);
		result_t r;
		r.position   = d[11:0];
		r.lead       = d[12];
		r.pairw      = d[13];
		r.badc       = d[14];
		r.status     = esc_pkg::bracket_status_t'(d[17:15]);
		r.code       = d[25:18];
		r.bpos       = d[37:26];
		r.openstr    = d[38];
		r.trail      = d[39];
		r.incomplete = d[40];
		r.endm       = l;
		return r;
	endfunction

	function automatic string fmt_result(input result_t r);
		return $sformatf({"pos=%0d lead=%0b pair=%0b bad=%0b st=%0d code=%02h bpos=%0d ",
			"str=%0b trail=%0b inc=%0b end=%0b"}, r.position, r.lead, r.pairw, r.badc,
			r.status, r.code, r.bpos, r.openstr, r.trail, r.incomplete, r.endm);
	endfunction

	// typed expectation for a final character with no operator-pair warning
	function automatic result_t end_result(input esc_pkg::pos_t p, input logic ld,
		input logic bc, input esc_pkg::bracket_status_t st, input esc_pkg::char_t cd,
		input esc_pkg::pos_t bp, input logic os, input logic tr, input logic ic);
		result_t r;
		r = '0;
		r.position = p;
		r.lead = ld;
		r.badc = bc;
		r.status = st;
		r.code = cd;
		r.bpos = bp;
		r.openstr = os;
		r.trail = tr;
		r.incomplete = ic;
		r.endm = 1'b1;
		return r;
	endfunction

	function automatic void add_row(input esc_pkg::char_t c, input logic last);
		row_t w;
		w.ch = c;
		w.last = last;
		w.typed = 1'b0;
		w.want = '0;
		dir_rows.insert(dir_rows.size(), w);
	endfunction

	function automatic void add_known(input esc_pkg::char_t c, input result_t want);
		row_t w;
		w.ch = c;
		w.last = 1'b1;
		w.typed = 1'b1;
		w.want = want;
		dir_rows.insert(dir_rows.size(), w);
	endfunction

	function automatic esc_pkg::char_t pick_alnum();
		int r;
		r = $urandom_range(35, 0);
		return (r < 26) ? esc_pkg::char_t'("a" + r) : esc_pkg::char_t'("0" + r - 26);
	endfunction

	function automatic esc_pkg::char_t pick_op();
		case ($urandom_range(11, 0))
			0:       return "+";
			1:       return "-";
			2:       return "*";
			3:       return "/";
			4:       return "^";
			5:       return "%";
			6:       return "<";
			7:       return ">";
			8:       return "=";
			9:       return "!";
			10:      return "&";
			default: return "|";
		endcase
	endfunction

	function automatic esc_pkg::char_t pick_filler();
		case ($urandom_range(5, 0))
			0:       return " ";
			1:       return esc_pkg::CH_TAB;
			2:       return esc_pkg::CH_LF;
			3:       return esc_pkg::CH_CR;
			4:       return ",";
			default: return ":";
		endcase
	endfunction

	// one expression into expr_text: mostly well formed, some broken or noise
	task automatic gen_expression();
		esc_pkg::kind_t open_k[$];
		esc_pkg::kind_t k;
		int             shape;
		int             target;
		int             r;
		int             n;
		expr_text.delete();
		shape = $urandom_range(99, 0);
		if (shape < 10) begin
			n = $urandom_range(10, 1);
			repeat (n) add_char(esc_pkg::char_t'($urandom_range(255, 0)));
		end else if (shape < 18) begin
			n = $urandom_range(40, 28);
			repeat (n) begin
				k = esc_pkg::kind_t'($urandom_range(2, 0));
				add_char(open_sym(k));
				open_k.insert(open_k.size(), k);
			end
			add_char(pick_alnum());
		end else begin
			target = $urandom_range(30, 1);
			while (expr_text.size() < target) begin
				r = $urandom_range(99, 0);
				if (r < 25) begin
					add_char(pick_alnum());
				end else if (r < 40) begin
					add_char(pick_op());
				end else if (r < 50) begin
					k = esc_pkg::kind_t'($urandom_range(2, 0));
					add_char(open_sym(k));
					open_k.insert(open_k.size(), k);
				end else if (r < 60) begin
					if (open_k.size() != 0) begin
						add_char(close_sym(open_k[$]));
						open_k.delete(open_k.size() - 1);
					end else begin
						add_char(close_sym(esc_pkg::kind_t'($urandom_range(2, 0))));
					end
				end else if (r < 68) begin
					add_char(esc_pkg::CH_DQUOTE);
					n = $urandom_range(5, 0);
					repeat (n) begin
						if ($urandom_range(3, 0) == 0) begin
							add_char(esc_pkg::CH_BSLASH);
							add_char(esc_pkg::char_t'($urandom_range(255, 0)));
						end else begin
							add_char(esc_pkg::char_t'($urandom_range(126, 32)));
						end
					end
					if ($urandom_range(6, 0) != 0)
						add_char(esc_pkg::CH_DQUOTE);
				end else if (r < 76) begin
					add_char(pick_filler());
				end else if (r < 79) begin
					add_char(esc_pkg::char_t'($urandom_range(255, 0)));
				end else if (r < 82 && open_k.size() != 0) begin
					k = esc_pkg::kind_t'((int'(open_k[$]) + $urandom_range(2, 1)) % 3);
					add_char(close_sym(k));
				end else begin
					add_char(pick_alnum());
				end
			end
		end
		if ($urandom_range(4, 0) != 0)
			while (open_k.size() != 0) begin
				add_char(close_sym(open_k[$]));
				open_k.delete(open_k.size() - 1);
			end
	endtask

	// one request on the input side, with bursty gaps
	task automatic send_char(input esc_pkg::char_t ch, input logic last, input logic typed,
		input result_t want);
		int      gap;
		result_t predicted;
		if (burst_left == 0) begin
			burst_left = $urandom_range(24, 1);
			gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= ch;
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predicted = scan_char(ch, last);
		expected_faults.insert(expected_faults.size(), typed ? want : predicted);
	endtask

	task automatic send_expression();
		for (int i = 0; i < expr_text.size(); i++)
			send_char(expr_text[i], i == expr_text.size() - 1, 1'b0, '0);
	endtask

	// receiver stall pattern and result check
	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (rx_left == 0) begin
			rx_left = $urandom_range(80, 10);
			rx_mode = $urandom_range(3, 0);
		end
		rx_left--;
		rx_phase++;
		if (arst_n && m_tvalid && m_tready) begin
			got = unpack_result(m_tdata, m_tlast);
			if (expected_faults.size() == 0) begin
				if (fails < 10)
					$display("unexpected result: %s", fmt_result(got));
				fails++;
			end else begin
				want = expected_faults.pop_front();
				if (got !== want) begin
					if (fails < 10)
						$display("mismatch\n  exp %s\n  act %s", fmt_result(want),
							fmt_result(got));
					fails++;
				end
			end
		end
		case (rx_mode)
			0:       m_tready <= 1'b1;
			1:       m_tready <= 1'($urandom_range(1, 0));
			2:       m_tready <= (rx_phase % 4 == 0);
			default: m_tready <= ($urandom_range(15, 0) == 0);
		endcase
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	initial begin
		int sent;
		clear_scan();

		add_known("*", end_result('0, 1'b1, 1'b0, esc_pkg::BS_NONE, '0, '0,
			1'b0, 1'b1, 1'b1));
		add_known("/", end_result('0, 1'b1, 1'b0, esc_pkg::BS_NONE, '0, '0,
			1'b0, 1'b1, 1'b1));
		add_known("(", end_result('0, 1'b0, 1'b0, esc_pkg::BS_UNCLOSED, "(", '0,
			1'b0, 1'b0, 1'b0));
		add_known(")", end_result('0, 1'b0, 1'b0, esc_pkg::BS_UNEXPECTED, ")", '0,
			1'b0, 1'b0, 1'b0));
		add_row("[", 1'b0);
		add_known("}", end_result(esc_pkg::pos_t'(1), 1'b0, 1'b0, esc_pkg::BS_MISMATCH, "]",
			esc_pkg::pos_t'(1), 1'b0, 1'b0, 1'b0));
		add_row(esc_pkg::CH_DQUOTE, 1'b0);
		add_row(esc_pkg::CH_BSLASH, 1'b0);
		add_row(esc_pkg::CH_DQUOTE, 1'b0);
		add_row(8'h01, 1'b0);
		add_row(esc_pkg::CH_DQUOTE, 1'b0);
		add_row(8'hFF, 1'b0);
		add_row(esc_pkg::CH_TAB, 1'b0);
		add_row("&", 1'b0);
		add_row("&", 1'b0);
		add_row("|", 1'b0);
		add_row("-", 1'b0);
		add_row("+", 1'b0);
		add_row("{", 1'b0);
		add_row("}", 1'b0);
		add_row(",", 1'b1);
		add_row(esc_pkg::CH_DQUOTE, 1'b0);
		add_known("q", end_result(esc_pkg::pos_t'(1), 1'b0, 1'b0, esc_pkg::BS_NONE, '0, '0,
			1'b1, 1'b0, 1'b0));
		add_row(8'h80, 1'b0);
		add_known(8'h00, end_result(esc_pkg::pos_t'(1), 1'b0, 1'b1, esc_pkg::BS_NONE, '0, '0,
			1'b0, 1'b0, 1'b0));
		add_row("%", 1'b0);
		add_known(":", end_result(esc_pkg::pos_t'(1), 1'b0, 1'b0, esc_pkg::BS_NONE, '0, '0,
			1'b0, 1'b0, 1'b1));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_char(dir_rows[i].ch, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].want);

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			gen_expression();
			send_expression();
			sent += expr_text.size();
		end

		s_tvalid <= 1'b0;
		while (expected_faults.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (fails == 0 && expected_faults.size() == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/esc_pkg.sv
sv/esc_stack.sv
sv/expression_syntax_checker.sv
dv/tb_top.sv
